// ===== design/plcm_pkg.sv =====
// Package for the piecewise-linear colormap core.
// Holds fixed-point widths, stop tables, colors, reciprocals and stage types.
// No dependencies.
`default_nettype none

package plcm_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LEVEL_W   = FRAC_BITS + 1;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SPAN_W    = FRAC_BITS + 1;
  localparam int unsigned NUM_W     = FRAC_BITS + CHAN_W;
  localparam int unsigned RECIP_W   = FRAC_BITS + 11;
  localparam int unsigned SHIFT     = 2 * FRAC_BITS + CHAN_W;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam int unsigned NSTOPS    = 6;
  localparam int unsigned NSEG      = NSTOPS - 1;
  localparam int unsigned SEG_W     = $clog2(NSTOPS);
  localparam int unsigned MODEL_W   = 2;

  localparam int unsigned CH_RED   = 2;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 0;

  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [CHAN_W-1:0]          chan_t;
  typedef logic [2:0][CHAN_W-1:0]     rgb_t;
  typedef logic [RECIP_W-1:0]         recip_t;
  typedef logic [SEG_W-1:0]           seg_idx_t;

  typedef enum logic [MODEL_W-1:0] {
    MODEL_GRAY    = 2'd0,
    MODEL_JET     = 2'd1,
    MODEL_THERMAL = 2'd2
  } model_t;

  function automatic level_t stop_q(input int unsigned hund);
    logic [63:0] wide;
    wide = (64'(hund) << FRAC_BITS) + 64'd50;
    return level_t'(wide / 64'd100);
  endfunction

  localparam level_t ONE_Q = level_t'(64'd1 << FRAC_BITS);

  localparam level_t JET_STOP [NSTOPS] = '{
    stop_q(0), stop_q(15), stop_q(35), stop_q(65), stop_q(85), stop_q(100)
  };
  localparam level_t THERM_STOP [NSTOPS] = '{
    stop_q(0), stop_q(15), stop_q(33), stop_q(60), stop_q(85), stop_q(100)
  };

  localparam rgb_t JET_RGB [NSTOPS] = '{
    {8'd0,   8'd0,   8'd100},
    {8'd0,   8'd50,  8'd255},
    {8'd0,   8'd255, 8'd255},
    {8'd255, 8'd255, 8'd0},
    {8'd255, 8'd30,  8'd0},
    {8'd100, 8'd0,   8'd0}
  };
  localparam rgb_t THERM_RGB [NSTOPS] = '{
    {8'd0,   8'd0,   8'd50},
    {8'd20,  8'd0,   8'd120},
    {8'd200, 8'd30,  8'd140},
    {8'd255, 8'd100, 8'd0},
    {8'd255, 8'd255, 8'd40},
    {8'd255, 8'd255, 8'd255}
  };

  localparam logic [63:0] RECIP_ONE = 64'd1 << SHIFT;

  localparam logic [63:0] JET_SPAN [NSEG] = '{
    64'(JET_STOP[1]) - 64'(JET_STOP[0]),
    64'(JET_STOP[2]) - 64'(JET_STOP[1]),
    64'(JET_STOP[3]) - 64'(JET_STOP[2]),
    64'(JET_STOP[4]) - 64'(JET_STOP[3]),
    64'(JET_STOP[5]) - 64'(JET_STOP[4])
  };
  localparam logic [63:0] THERM_SPAN [NSEG] = '{
    64'(THERM_STOP[1]) - 64'(THERM_STOP[0]),
    64'(THERM_STOP[2]) - 64'(THERM_STOP[1]),
    64'(THERM_STOP[3]) - 64'(THERM_STOP[2]),
    64'(THERM_STOP[4]) - 64'(THERM_STOP[3]),
    64'(THERM_STOP[5]) - 64'(THERM_STOP[4])
  };

  localparam recip_t JET_RECIP [NSEG] = '{
    RECIP_W'((RECIP_ONE + JET_SPAN[0] - 64'd1) / JET_SPAN[0]),
    RECIP_W'((RECIP_ONE + JET_SPAN[1] - 64'd1) / JET_SPAN[1]),
    RECIP_W'((RECIP_ONE + JET_SPAN[2] - 64'd1) / JET_SPAN[2]),
    RECIP_W'((RECIP_ONE + JET_SPAN[3] - 64'd1) / JET_SPAN[3]),
    RECIP_W'((RECIP_ONE + JET_SPAN[4] - 64'd1) / JET_SPAN[4])
  };
  localparam recip_t THERM_RECIP [NSEG] = '{
    RECIP_W'((RECIP_ONE + THERM_SPAN[0] - 64'd1) / THERM_SPAN[0]),
    RECIP_W'((RECIP_ONE + THERM_SPAN[1] - 64'd1) / THERM_SPAN[1]),
    RECIP_W'((RECIP_ONE + THERM_SPAN[2] - 64'd1) / THERM_SPAN[2]),
    RECIP_W'((RECIP_ONE + THERM_SPAN[3] - 64'd1) / THERM_SPAN[3]),
    RECIP_W'((RECIP_ONE + THERM_SPAN[4] - 64'd1) / THERM_SPAN[4])
  };

  localparam recip_t GRAY_RECIP = RECIP_W'(64'd1 << (SHIFT - FRAC_BITS));
  localparam rgb_t   GRAY_A     = {3{8'd255}};

  typedef struct packed {
    logic   valid;
    logic   ok;
    level_t lvl;
    level_t lo;
    level_t hi;
    rgb_t   a;
    rgb_t   b;
    recip_t recip;
  } seg_stage_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [SPAN_W-1:0] d_hi;
    logic [SPAN_W-1:0] d_lo;
    rgb_t              a;
    rgb_t              b;
    recip_t            recip;
  } diff_stage_t;

  typedef struct packed {
    logic                   valid;
    logic                   ok;
    logic [2:0][NUM_W-1:0]  num;
    recip_t                 recip;
  } num_stage_t;

endpackage

`default_nettype wire

// ===== design/piecewise_linear_colormap_core.sv =====
// Top level of the piecewise-linear colormap: config register and the
// five-stage pipeline. Depends on plcm_pkg, plcm_seg, plcm_blend, plcm_scale.
//
// Takes one level per clock: busy stays low, so start may be high in every
// cycle. Each item gives one result, marked by out_strobe, in order, after it
// passes the five register stages: segment select, end distances, weighted
// sum, reciprocal multiply and output. The receiver cannot stall the results.
// Write cfg_color_model only while no item is in flight.
`default_nettype none

module piecewise_linear_colormap_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [plcm_pkg::MODEL_W-1:0]        cfg_color_model,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [plcm_pkg::LEVEL_W-1:0]        in_level,
  output logic                                     out_strobe,
  output logic [plcm_pkg::CHAN_W-1:0]              out_red,
  output logic [plcm_pkg::CHAN_W-1:0]              out_green,
  output logic [plcm_pkg::CHAN_W-1:0]              out_blue,
  output logic                                     out_valid_res
);

  logic [plcm_pkg::MODEL_W-1:0] model_r, model_nxt;
  plcm_pkg::seg_stage_t         seg;
  plcm_pkg::num_stage_t         num;

  assign busy      = 1'b0;
  assign model_nxt = cfg_we ? cfg_color_model : model_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= plcm_pkg::MODEL_GRAY;
    end else begin
      model_r <= model_nxt;
    end
  end

  plcm_seg u_seg (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (start & ~busy),
    .level (in_level),
    .model (model_r),
    .seg_o (seg)
  );

  plcm_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .seg_i (seg),
    .num_o (num)
  );

  plcm_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .num_i      (num),
    .res_strobe (out_strobe),
    .res_red    (out_red),
    .res_green  (out_green),
    .res_blue   (out_blue),
    .res_ok     (out_valid_res)
  );

endmodule

`default_nettype wire

// ===== design/plcm_seg.sv =====
// Segment select stage: finds the map segment holding the level and loads
// its stop positions, end colors and reciprocal. Depends on plcm_pkg.
`default_nettype none

module plcm_seg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire plcm_pkg::level_t               level,
  input  wire logic [plcm_pkg::MODEL_W-1:0]   model,
  output plcm_pkg::seg_stage_t                seg_o
);

  plcm_pkg::seg_stage_t s_r, s_nxt;
  plcm_pkg::level_t     stops [plcm_pkg::NSTOPS];
  plcm_pkg::rgb_t       cols  [plcm_pkg::NSTOPS];
  plcm_pkg::recip_t     recs  [plcm_pkg::NSEG];
  plcm_pkg::seg_idx_t   sel;
  plcm_pkg::seg_idx_t   sel_hi;
  logic                 in_range;

  always_comb begin
    if (model == plcm_pkg::MODEL_THERMAL) begin
      stops = plcm_pkg::THERM_STOP;
      cols  = plcm_pkg::THERM_RGB;
      recs  = plcm_pkg::THERM_RECIP;
    end else begin
      stops = plcm_pkg::JET_STOP;
      cols  = plcm_pkg::JET_RGB;
      recs  = plcm_pkg::JET_RECIP;
    end
    sel = plcm_pkg::seg_idx_t'(plcm_pkg::NSEG - 1);
    for (int i = plcm_pkg::NSEG - 1; i >= 0; i--) begin
      if (level <= stops[i + 1]) begin
        sel = plcm_pkg::seg_idx_t'(i);
      end
    end
    sel_hi   = sel + plcm_pkg::seg_idx_t'(1);
    in_range = (level <= plcm_pkg::ONE_Q);

    s_nxt.valid = take;
    s_nxt.lvl   = level;
    s_nxt.ok    = 1'b0;
    s_nxt.lo    = '0;
    s_nxt.hi    = plcm_pkg::ONE_Q;
    s_nxt.a     = '0;
    s_nxt.b     = '0;
    s_nxt.recip = plcm_pkg::GRAY_RECIP;
    case (model)
      plcm_pkg::MODEL_GRAY: begin
        if (in_range) begin
          s_nxt.ok = 1'b1;
          s_nxt.a  = plcm_pkg::GRAY_A;
        end
      end
      plcm_pkg::MODEL_JET, plcm_pkg::MODEL_THERMAL: begin
        if (in_range) begin
          s_nxt.ok    = 1'b1;
          s_nxt.lo    = stops[sel];
          s_nxt.hi    = stops[sel_hi];
          s_nxt.a     = cols[sel];
          s_nxt.b     = cols[sel_hi];
          s_nxt.recip = recs[sel];
        end
      end
      default: begin
        s_nxt.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else begin
      s_r.valid <= s_nxt.valid;
    end
    s_r.ok    <= s_nxt.ok;
    s_r.lvl   <= s_nxt.lvl;
    s_r.lo    <= s_nxt.lo;
    s_r.hi    <= s_nxt.hi;
    s_r.a     <= s_nxt.a;
    s_r.b     <= s_nxt.b;
    s_r.recip <= s_nxt.recip;
  end

  assign seg_o = s_r;

endmodule

`default_nettype wire

// ===== design/plcm_blend.sv =====
// Blend stages: distances to both segment ends, then the weighted color sum
// a*(hi-level) + b*(level-lo) per channel. Depends on plcm_pkg.
`default_nettype none

module plcm_blend (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plcm_pkg::seg_stage_t seg_i,
  output plcm_pkg::num_stage_t      num_o
);

  plcm_pkg::diff_stage_t d_r, d_nxt;
  plcm_pkg::num_stage_t  n_r, n_nxt;

  always_comb begin
    d_nxt.valid = seg_i.valid;
    d_nxt.ok    = seg_i.ok;
    d_nxt.d_hi  = plcm_pkg::SPAN_W'(seg_i.hi - seg_i.lvl);
    d_nxt.d_lo  = plcm_pkg::SPAN_W'(seg_i.lvl - seg_i.lo);
    d_nxt.a     = seg_i.a;
    d_nxt.b     = seg_i.b;
    d_nxt.recip = seg_i.recip;
  end

  always_comb begin
    n_nxt.valid = d_r.valid;
    n_nxt.ok    = d_r.ok;
    n_nxt.recip = d_r.recip;
    for (int c = 0; c < 3; c++) begin
      n_nxt.num[c] = plcm_pkg::NUM_W'(
        plcm_pkg::NUM_W'(d_r.a[c]) * plcm_pkg::NUM_W'(d_r.d_hi) +
        plcm_pkg::NUM_W'(d_r.b[c]) * plcm_pkg::NUM_W'(d_r.d_lo));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
      n_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
      n_r.valid <= n_nxt.valid;
    end
    d_r.ok    <= d_nxt.ok;
    d_r.d_hi  <= d_nxt.d_hi;
    d_r.d_lo  <= d_nxt.d_lo;
    d_r.a     <= d_nxt.a;
    d_r.b     <= d_nxt.b;
    d_r.recip <= d_nxt.recip;
    n_r.ok    <= n_nxt.ok;
    n_r.num   <= n_nxt.num;
    n_r.recip <= n_nxt.recip;
  end

  assign num_o = n_r;

endmodule

`default_nettype wire

// ===== design/plcm_scale.sv =====
// Scale stages: multiplies each weighted sum by the segment reciprocal and
// drives the registered result. Depends on plcm_pkg.
`default_nettype none

module plcm_scale (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plcm_pkg::num_stage_t num_i,
  output logic                      res_strobe,
  output plcm_pkg::chan_t           res_red,
  output plcm_pkg::chan_t           res_green,
  output plcm_pkg::chan_t           res_blue,
  output logic                      res_ok
);

  logic                                  p_valid_r;
  logic                                  p_ok_r;
  logic [2:0][plcm_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic                                  strobe_r;
  logic                                  ok_r;
  plcm_pkg::rgb_t                        rgb_r, rgb_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = plcm_pkg::PROD_W'(num_i.num[c]) * plcm_pkg::PROD_W'(num_i.recip);
      rgb_nxt[c]  = prod_r[c][plcm_pkg::SHIFT +: plcm_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      p_valid_r <= num_i.valid;
      strobe_r  <= p_valid_r;
    end
    p_ok_r <= num_i.ok;
    prod_r <= prod_nxt;
    ok_r   <= p_ok_r;
    rgb_r  <= rgb_nxt;
  end

  assign res_strobe = strobe_r;
  assign res_red    = rgb_r[plcm_pkg::CH_RED];
  assign res_green  = rgb_r[plcm_pkg::CH_GREEN];
  assign res_blue   = rgb_r[plcm_pkg::CH_BLUE];
  assign res_ok     = ok_r;

endmodule

`default_nettype wire
